@@ hdl/sic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_pkg
// Shared widths, types and helpers of the segment intersection classifier.
// ----------------------------------------------------------------------------
package sic_pkg;

    // coordinate and datapath widths
    localparam int CW     = 16;          // Q12.4 coordinate
    localparam int DIFF_W = CW + 1;      // coordinate difference
    localparam int PROD_W = 2 * DIFF_W;  // difference product
    localparam int XW     = PROD_W + 1;  // cross product
    localparam int PAW    = XW + DIFF_W; // numerator times difference
    localparam int RF     = 16;          // ratio fraction bits
    localparam int QW     = RF + 2;      // quotient bits, one per cell
    localparam int NW     = PAW + 1;     // rounded dividend
    localparam int DW     = XW + 1;      // doubled divisor
    localparam int VW     = QW + 3;      // signed ratio / point sum
    localparam int NCELL  = QW;
    localparam int NLANE  = 4;
    localparam int CTW    = 20;          // cross tolerance width
    localparam int TW     = 16;          // ratio tolerance and margin width

    // lanes of the divider
    localparam int LANE_T  = 0;
    localparam int LANE_U  = 1;
    localparam int LANE_PX = 2;
    localparam int LANE_PY = 3;

    localparam logic signed [VW-1:0] RATIO_ONE = VW'(1 << RF);
    localparam logic signed [VW-1:0] COORD_MAX = VW'((1 << (CW - 1)) - 1);
    localparam logic signed [VW-1:0] COORD_MIN = -COORD_MAX - VW'(1);

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_OVERLAP = 2'd1,
        KIND_CROSS   = 2'd2,
        KIND_VERTEX  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_CROSS_TOL   = 2'd0,
        CFG_RATIO_TOL   = 2'd1,
        CFG_EDGE_MARGIN = 2'd2
    } cfg_idx_t;

    // one lane of the long division
    typedef struct packed {
        logic          ovf;
        logic [QW-1:0] q;
        logic [DW-1:0] r;
        logic [QW-1:0] nlo;
    } lane_t;

    // data that rides along the divider chain
    typedef struct packed {
        logic                 parallel;
        logic                 overlap;
        logic [NLANE-1:0]     neg;
        logic signed [CW-1:0] ax0;
        logic signed [CW-1:0] ay0;
    } side_t;

    typedef struct packed {
        logic [DW-1:0]           d;
        side_t                   side;
        lane_t [NLANE-1:0]       lane;
    } div_item_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 at_a_begin;
        logic                 at_a_end;
        logic                 at_b_begin;
        logic                 at_b_end;
        logic                 point_valid;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
    } result_t;

    function automatic logic [XW-1:0] mag_x(input logic signed [XW-1:0] v);
        return v[XW-1] ? XW'(-v) : XW'(v);
    endfunction

    function automatic logic [PAW-1:0] mag_p(input logic signed [PAW-1:0] v);
        return v[PAW-1] ? PAW'(-v) : PAW'(v);
    endfunction

    function automatic logic extents_overlap(input logic signed [CW-1:0] a0,
                                             input logic signed [CW-1:0] a1,
                                             input logic signed [CW-1:0] b0,
                                             input logic signed [CW-1:0] b1);
        logic signed [CW-1:0] alo, ahi, blo, bhi;
        alo = (a0 < a1) ? a0 : a1;
        ahi = (a0 < a1) ? a1 : a0;
        blo = (b0 < b1) ? b0 : b1;
        bhi = (b0 < b1) ? b1 : b0;
        return !((alo > bhi) || (ahi < blo));
    endfunction

    // first step of a lane: overflow check and top remainder
    function automatic lane_t make_lane(input logic [NW-1:0] n, input logic [DW-1:0] d);
        lane_t l;
        l.ovf = ({1'b0, n[NW-1:QW]} >= d);
        l.q   = '0;
        l.r   = {1'b0, n[NW-1:QW]};
        l.nlo = n[QW-1:0];
        return l;
    endfunction

    // signed quotient, clamped when it overflowed
    function automatic logic signed [VW-1:0] lane_val(input lane_t l, input logic neg);
        logic [VW-1:0] qe;
        qe = l.ovf ? {3'b000, {QW{1'b1}}} : {3'b000, l.q};
        return neg ? $signed(-qe) : $signed(qe);
    endfunction

endpackage

@@ hdl/sic_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_front
// Differences, cross products and dividends feeding the divider chain.
// ----------------------------------------------------------------------------
module sic_front
    import sic_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic signed [CW-1:0] a_begin_x,
    input  logic signed [CW-1:0] a_begin_y,
    input  logic signed [CW-1:0] a_end_x,
    input  logic signed [CW-1:0] a_end_y,
    input  logic signed [CW-1:0] b_begin_x,
    input  logic signed [CW-1:0] b_begin_y,
    input  logic signed [CW-1:0] b_end_x,
    input  logic signed [CW-1:0] b_end_y,
    input  logic [CTW-1:0]       cross_tol,
    output logic                 out_vld,
    output div_item_t            out_item
);

    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg, vld_e_reg;

    // stage a: captured coordinates
    logic signed [CW-1:0] ax0_a_reg, ay0_a_reg, ax1_a_reg, ay1_a_reg;
    logic signed [CW-1:0] bx0_a_reg, by0_a_reg, bx1_a_reg, by1_a_reg;

    // stage b: differences
    logic signed [DIFF_W-1:0] dax_b_reg, day_b_reg, dbx_b_reg, dby_b_reg;
    logic signed [DIFF_W-1:0] dx_b_reg, dy_b_reg;
    logic signed [CW-1:0]     ax0_b_reg, ay0_b_reg;
    logic                     ov_b_reg;
    logic signed [DIFF_W-1:0] dax_next, dbx_next;
    logic                     ov_next;

    // stage c: products
    logic signed [PROD_W-1:0] p1_c_reg, p2_c_reg, p3_c_reg, p4_c_reg, p5_c_reg, p6_c_reg;
    logic signed [DIFF_W-1:0] dax_c_reg, day_c_reg;
    logic signed [CW-1:0]     ax0_c_reg, ay0_c_reg;
    logic                     ov_c_reg;

    // stage d: cross products
    logic signed [XW-1:0]     cross_d_reg, na_d_reg, nb_d_reg;
    logic signed [DIFF_W-1:0] dax_d_reg, day_d_reg;
    logic signed [CW-1:0]     ax0_d_reg, ay0_d_reg;
    logic                     ov_d_reg;

    // stage e: magnitudes and point numerators
    logic [XW-1:0]         xmag_e_reg, namag_e_reg, nbmag_e_reg;
    logic signed [PAW-1:0] pax_e_reg, pay_e_reg;
    logic                  xneg_e_reg, naneg_e_reg, nbneg_e_reg;
    logic                  parallel_e_reg, coll_e_reg;
    logic signed [CW-1:0]  ax0_e_reg, ay0_e_reg;
    logic [XW-1:0]         xmag_next, nbmag_next;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
            vld_e_reg <= vld_d_reg;
        end
    end

    // extent overlap, y extents when both segments are vertical
    always_comb
    begin
        dax_next = DIFF_W'(ax1_a_reg) - DIFF_W'(ax0_a_reg);
        dbx_next = DIFF_W'(bx1_a_reg) - DIFF_W'(bx0_a_reg);
        if ((dax_next == '0) && (dbx_next == '0))
            ov_next = extents_overlap(ay0_a_reg, ay1_a_reg, by0_a_reg, by1_a_reg);
        else
            ov_next = extents_overlap(ax0_a_reg, ax1_a_reg, bx0_a_reg, bx1_a_reg);
    end

    assign xmag_next  = mag_x(cross_d_reg);
    assign nbmag_next = mag_x(nb_d_reg);

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax0_a_reg <= a_begin_x;
            ay0_a_reg <= a_begin_y;
            ax1_a_reg <= a_end_x;
            ay1_a_reg <= a_end_y;
            bx0_a_reg <= b_begin_x;
            by0_a_reg <= b_begin_y;
            bx1_a_reg <= b_end_x;
            by1_a_reg <= b_end_y;

            dax_b_reg <= dax_next;
            day_b_reg <= DIFF_W'(ay1_a_reg) - DIFF_W'(ay0_a_reg);
            dbx_b_reg <= dbx_next;
            dby_b_reg <= DIFF_W'(by1_a_reg) - DIFF_W'(by0_a_reg);
            dx_b_reg  <= DIFF_W'(ax0_a_reg) - DIFF_W'(bx0_a_reg);
            dy_b_reg  <= DIFF_W'(ay0_a_reg) - DIFF_W'(by0_a_reg);
            ax0_b_reg <= ax0_a_reg;
            ay0_b_reg <= ay0_a_reg;
            ov_b_reg  <= ov_next;

            p1_c_reg  <= PROD_W'(dax_b_reg * dby_b_reg);
            p2_c_reg  <= PROD_W'(day_b_reg * dbx_b_reg);
            p3_c_reg  <= PROD_W'(dbx_b_reg * dy_b_reg);
            p4_c_reg  <= PROD_W'(dby_b_reg * dx_b_reg);
            p5_c_reg  <= PROD_W'(dax_b_reg * dy_b_reg);
            p6_c_reg  <= PROD_W'(day_b_reg * dx_b_reg);
            dax_c_reg <= dax_b_reg;
            day_c_reg <= day_b_reg;
            ax0_c_reg <= ax0_b_reg;
            ay0_c_reg <= ay0_b_reg;
            ov_c_reg  <= ov_b_reg;

            cross_d_reg <= XW'(p1_c_reg) - XW'(p2_c_reg);
            na_d_reg    <= XW'(p3_c_reg) - XW'(p4_c_reg);
            nb_d_reg    <= XW'(p5_c_reg) - XW'(p6_c_reg);
            dax_d_reg   <= dax_c_reg;
            day_d_reg   <= day_c_reg;
            ax0_d_reg   <= ax0_c_reg;
            ay0_d_reg   <= ay0_c_reg;
            ov_d_reg    <= ov_c_reg;

            xmag_e_reg     <= xmag_next;
            namag_e_reg    <= mag_x(na_d_reg);
            nbmag_e_reg    <= nbmag_next;
            xneg_e_reg     <= cross_d_reg[XW-1];
            naneg_e_reg    <= na_d_reg[XW-1];
            nbneg_e_reg    <= nb_d_reg[XW-1];
            pax_e_reg      <= PAW'(na_d_reg * dax_d_reg);
            pay_e_reg      <= PAW'(na_d_reg * day_d_reg);
            parallel_e_reg <= (xmag_next < XW'(cross_tol));
            coll_e_reg     <= (nbmag_next < XW'(cross_tol)) && ov_d_reg;
            ax0_e_reg      <= ax0_d_reg;
            ay0_e_reg      <= ay0_d_reg;
        end
    end

    // dividends rounded to nearest: (2n + d) / 2d
    always_comb
    begin
        logic [DW-1:0] d2;
        d2 = {xmag_e_reg, 1'b0};
        out_item.d                  = d2;
        out_item.side.parallel      = parallel_e_reg;
        out_item.side.overlap       = coll_e_reg;
        out_item.side.neg[LANE_T]   = naneg_e_reg ^ xneg_e_reg;
        out_item.side.neg[LANE_U]   = nbneg_e_reg ^ xneg_e_reg;
        out_item.side.neg[LANE_PX]  = pax_e_reg[PAW-1] ^ xneg_e_reg;
        out_item.side.neg[LANE_PY]  = pay_e_reg[PAW-1] ^ xneg_e_reg;
        out_item.side.ax0           = ax0_e_reg;
        out_item.side.ay0           = ay0_e_reg;
        out_item.lane[LANE_T]  = make_lane(NW'({namag_e_reg, {(RF + 1){1'b0}}})
                                           + NW'(xmag_e_reg), d2);
        out_item.lane[LANE_U]  = make_lane(NW'({nbmag_e_reg, {(RF + 1){1'b0}}})
                                           + NW'(xmag_e_reg), d2);
        out_item.lane[LANE_PX] = make_lane(NW'({mag_p(pax_e_reg), 1'b0})
                                           + NW'(xmag_e_reg), d2);
        out_item.lane[LANE_PY] = make_lane(NW'({mag_p(pay_e_reg), 1'b0})
                                           + NW'(xmag_e_reg), d2);
    end

    assign out_vld = vld_e_reg;

endmodule

@@ hdl/sic_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_div_cell
// One restoring division step for all four lanes, registered.
// ----------------------------------------------------------------------------
module sic_div_cell
    import sic_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_vld,
    input  div_item_t in_item,
    output logic      out_vld,
    output div_item_t out_item
);

    logic      vld_reg;
    div_item_t item_reg;
    div_item_t item_next;

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        logic [DW:0] rs;
        logic [DW:0] diff;
        logic        ge;
        item_next = in_item;
        for (int i = 0; i < NLANE; i++)
        begin
            rs   = {in_item.lane[i].r, in_item.lane[i].nlo[QW-1]};
            diff = rs - {1'b0, in_item.d};
            ge   = (rs >= {1'b0, in_item.d});
            item_next.lane[i].r   = ge ? diff[DW-1:0] : rs[DW-1:0];
            item_next.lane[i].q   = {in_item.lane[i].q[QW-2:0], ge};
            item_next.lane[i].nlo = {in_item.lane[i].nlo[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

@@ hdl/sic_finish.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_finish
// Range tests, vertex flags and point saturation from the quotients.
// ----------------------------------------------------------------------------
module sic_finish
    import sic_pkg::*;
(
    input  div_item_t     item,
    input  logic [TW-1:0] ratio_tol,
    input  logic [TW-1:0] edge_margin,
    output result_t       res
);

    logic signed [VW-1:0] t, u, qx, qy, sx, sy, m, rt;
    logic                 on_seg;
    logic [1:0]           ft, fu;

    function automatic logic signed [VW-1:0] mag_v(input logic signed [VW-1:0] v);
        return v[VW-1] ? -v : v;
    endfunction

    // {at end, at begin} of one segment
    function automatic logic [1:0] vflags(input logic signed [VW-1:0] r,
                                          input logic signed [VW-1:0] tol);
        logic [1:0] f;
        f = 2'b00;
        if (mag_v(r) < tol)
            f = 2'b01;
        else if (mag_v(r - RATIO_ONE) < tol)
            f = 2'b10;
        return f;
    endfunction

    always_comb
    begin
        t  = lane_val(item.lane[LANE_T], item.side.neg[LANE_T]);
        u  = lane_val(item.lane[LANE_U], item.side.neg[LANE_U]);
        qx = lane_val(item.lane[LANE_PX], item.side.neg[LANE_PX]);
        qy = lane_val(item.lane[LANE_PY], item.side.neg[LANE_PY]);
        m  = $signed(VW'(edge_margin));
        rt = $signed(VW'(ratio_tol));
        sx = VW'(item.side.ax0) + qx;
        sy = VW'(item.side.ay0) + qy;

        on_seg = (t > -m) && (t < RATIO_ONE + m) && (u > -m) && (u < RATIO_ONE + m);
        ft = vflags(t, rt);
        fu = vflags(u, rt);

        res = '0;
        if (item.side.parallel)
        begin
            res.kind = item.side.overlap ? KIND_OVERLAP : KIND_NONE;
        end
        else
        begin
            res.point_valid = 1'b1;
            // saturate the point to the coordinate range
            if (sx > COORD_MAX)
                res.point_x = CW'(COORD_MAX);
            else if (sx < COORD_MIN)
                res.point_x = CW'(COORD_MIN);
            else
                res.point_x = sx[CW-1:0];
            if (sy > COORD_MAX)
                res.point_y = CW'(COORD_MAX);
            else if (sy < COORD_MIN)
                res.point_y = CW'(COORD_MIN);
            else
                res.point_y = sy[CW-1:0];
            if (on_seg)
            begin
                res.at_a_begin = ft[0];
                res.at_a_end   = ft[1];
                res.at_b_begin = fu[0];
                res.at_b_end   = fu[1];
                res.kind = ((ft | fu) != 2'b00) ? KIND_VERTEX : KIND_CROSS;
            end
        end
    end

endmodule

@@ hdl/segment_intersection_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_classifier_top
// Classifies how two 2D segments meet and reports their line crossing point.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock while not held by a stall: five front
// stages form differences, products, cross products and rounded dividends,
// then a row of 18 division cells produces one quotient bit per cycle for
// the two line ratios and the two point offsets together, and a finishing
// stage feeds the output register. The whole pipeline holds only while a
// result waits in the output register under stall. Configuration writes are
// always taken (cfg_ready is high) and must come while no pair is in flight.
module segment_intersection_classifier_top
    import sic_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [CW-1:0] a_begin_x,
    input  logic signed [CW-1:0] a_begin_y,
    input  logic signed [CW-1:0] a_end_x,
    input  logic signed [CW-1:0] a_end_y,
    input  logic signed [CW-1:0] b_begin_x,
    input  logic signed [CW-1:0] b_begin_y,
    input  logic signed [CW-1:0] b_end_x,
    input  logic signed [CW-1:0] b_end_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           meet_kind,
    output logic                 at_a_begin,
    output logic                 at_a_end,
    output logic                 at_b_begin,
    output logic                 at_b_end,
    output logic                 point_valid,
    output logic signed [CW-1:0] point_x,
    output logic signed [CW-1:0] point_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [CTW-1:0]       cfg_data
);

    logic [CTW-1:0] cross_tol_reg;
    logic [TW-1:0]  ratio_tol_reg, edge_margin_reg;
    logic           en;
    logic           vld_chain [NCELL+1];
    div_item_t      item_chain [NCELL+1];
    result_t        res, res_reg;
    logic           out_valid_reg;

    // pipeline advances unless a result is held under stall
    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_tol_reg   <= CTW'(1);
            ratio_tol_reg   <= TW'(16);
            edge_margin_reg <= TW'(16);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CROSS_TOL:   cross_tol_reg   <= cfg_data;
                CFG_RATIO_TOL:   ratio_tol_reg   <= cfg_data[TW-1:0];
                CFG_EDGE_MARGIN: edge_margin_reg <= cfg_data[TW-1:0];
                default:         ;
            endcase
        end
    end

    sic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (in_valid),
        .a_begin_x (a_begin_x),
        .a_begin_y (a_begin_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_begin_x (b_begin_x),
        .b_begin_y (b_begin_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .cross_tol (cross_tol_reg),
        .out_vld   (vld_chain[0]),
        .out_item  (item_chain[0])
    );

    // row of division cells
    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        sic_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (vld_chain[g]),
            .in_item  (item_chain[g]),
            .out_vld  (vld_chain[g+1]),
            .out_item (item_chain[g+1])
        );
    end

    sic_finish u_finish (
        .item        (item_chain[NCELL]),
        .ratio_tol   (ratio_tol_reg),
        .edge_margin (edge_margin_reg),
        .res         (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_chain[NCELL];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign meet_kind   = res_reg.kind;
    assign at_a_begin  = res_reg.at_a_begin;
    assign at_a_end    = res_reg.at_a_end;
    assign at_b_begin  = res_reg.at_b_begin;
    assign at_b_end    = res_reg.at_b_end;
    assign point_valid = res_reg.point_valid;
    assign point_x     = res_reg.point_x;
    assign point_y     = res_reg.point_y;

endmodule

@@ hdl/sic_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_checker
// Port-level checks on the classifier results, bound to the top level.
// ----------------------------------------------------------------------------
module sic_checker
    import sic_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [1:0]           meet_kind,
    input logic                 at_a_begin,
    input logic                 at_a_end,
    input logic                 at_b_begin,
    input logic                 at_b_end,
    input logic                 point_valid,
    input logic signed [CW-1:0] point_x,
    input logic signed [CW-1:0] point_y
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(meet_kind))
        else $error("stalled result changed");

    // parallel lines carry no point and no flags
    a_parallel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> point_x == '0 && point_y == '0
            && !at_a_begin && !at_a_end && !at_b_begin && !at_b_end)
        else $error("parallel result has point or flags");

    // a segment is never at both of its ends
    a_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(at_a_begin && at_a_end) && !(at_b_begin && at_b_end))
        else $error("both ends flagged");

    // kind agrees with flags and point
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((meet_kind == KIND_VERTEX) ==
            (at_a_begin || at_a_end || at_b_begin || at_b_end))
            && ((meet_kind == KIND_OVERLAP) ? !point_valid : 1'b1)
            && ((meet_kind == KIND_CROSS || meet_kind == KIND_VERTEX) ? point_valid : 1'b1))
        else $error("kind inconsistent");

endmodule

bind segment_intersection_classifier_top sic_checker u_sic_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the segment intersection classifier. A clocked driver sends
// segment pairs from a queue and a clocked monitor checks every result
// against an in-bench prediction of the meet kind, the vertex flags and the
// saturated crossing point, under several tolerance settings and idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import sic_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0] ax0;
        logic signed [CW-1:0] ay0;
        logic signed [CW-1:0] ax1;
        logic signed [CW-1:0] ay1;
        logic signed [CW-1:0] bx0;
        logic signed [CW-1:0] by0;
        logic signed [CW-1:0] bx1;
        logic signed [CW-1:0] by1;
    } seg_pair_t;

    localparam int STALL_LIMIT = 3000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    seg_pair_t      drv_pair = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    logic [1:0]     meet_kind;
    logic           at_a_begin, at_a_end, at_b_begin, at_b_end;
    logic           point_valid;
    logic signed [CW-1:0] point_x, point_y;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = '0;
    logic [CTW-1:0] cfg_data = '0;

    // tolerances as the block should hold them
    longint         tol_cross = 1;
    longint         tol_ratio = 16;
    longint         tol_margin = 16;

    seg_pair_t      pending_pairs[$];
    result_t        expected_meets[$];
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    int             fail_count = 0;
    int             quiet_cycles = 0;

    segment_intersection_classifier_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .a_begin_x  (drv_pair.ax0),
        .a_begin_y  (drv_pair.ay0),
        .a_end_x    (drv_pair.ax1),
        .a_end_y    (drv_pair.ay1),
        .b_begin_x  (drv_pair.bx0),
        .b_begin_y  (drv_pair.by0),
        .b_end_x    (drv_pair.bx1),
        .b_end_y    (drv_pair.by1),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .meet_kind  (meet_kind),
        .at_a_begin (at_a_begin),
        .at_a_end   (at_a_end),
        .at_b_begin (at_b_begin),
        .at_b_end   (at_b_end),
        .point_valid(point_valid),
        .point_x    (point_x),
        .point_y    (point_y),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // n * 2^sh / d rounded to nearest, ties away from zero
    function automatic longint div_round(longint n, longint d, int sh);
        longint unsigned un, ud, q;
        un = longint'(abs64(n)) << sh;
        ud = abs64(d);
        q  = (2 * un + ud) / (2 * ud);
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return CW'(v);
    endfunction

    function automatic logic spans_meet(longint a0, longint a1, longint b0, longint b1);
        longint alo, ahi, blo, bhi;
        alo = (a0 < a1) ? a0 : a1;
        ahi = (a0 < a1) ? a1 : a0;
        blo = (b0 < b1) ? b0 : b1;
        bhi = (b0 < b1) ? b1 : b0;
        return !(alo > bhi || ahi < blo);
    endfunction

    function automatic longint direction_cross(seg_pair_t p);
        return (longint'(p.ax1) - p.ax0) * (longint'(p.by1) - p.by0)
             - (longint'(p.ay1) - p.ay0) * (longint'(p.bx1) - p.bx0);
    endfunction

    // begin or end flag of one segment from its ratio
    function automatic logic [1:0] ratio_vertex(longint r);
        if (abs64(r) < tol_ratio)
            return 2'b01;
        if (abs64(r - 65536) < tol_ratio)
            return 2'b10;
        return 2'b00;
    endfunction

    function automatic result_t predict_meet(seg_pair_t p);
        result_t res;
        longint dax, day, dbx, dby, dx, dy, crs, num_a, num_b, t, u;
        logic [1:0] fa, fb;
        dax   = longint'(p.ax1) - p.ax0;
        day   = longint'(p.ay1) - p.ay0;
        dbx   = longint'(p.bx1) - p.bx0;
        dby   = longint'(p.by1) - p.by0;
        dx    = longint'(p.ax0) - p.bx0;
        dy    = longint'(p.ay0) - p.by0;
        crs   = dax * dby - day * dbx;
        num_a = dbx * dy - dby * dx;
        num_b = dax * dy - day * dx;
        res   = '0;
        if (abs64(crs) < tol_cross)
        begin
            if (abs64(num_b) < tol_cross)
            begin
                if ((dax == 0 && dbx == 0) ? spans_meet(p.ay0, p.ay1, p.by0, p.by1)
                                           : spans_meet(p.ax0, p.ax1, p.bx0, p.bx1))
                    res.kind = KIND_OVERLAP;
            end
        end
        else
        begin
            t = div_round(num_a, crs, RF);
            u = div_round(num_b, crs, RF);
            res.point_valid = 1'b1;
            res.point_x = clamp_coord(longint'(p.ax0) + div_round(num_a * dax, crs, 0));
            res.point_y = clamp_coord(longint'(p.ay0) + div_round(num_a * day, crs, 0));
            if (t > -tol_margin && t < 65536 + tol_margin &&
                u > -tol_margin && u < 65536 + tol_margin)
            begin
                fa = ratio_vertex(t);
                fb = ratio_vertex(u);
                {res.at_a_end, res.at_a_begin} = fa;
                {res.at_b_end, res.at_b_begin} = fb;
                res.kind = (fa != 0 || fb != 0) ? KIND_VERTEX : KIND_CROSS;
            end
        end
        return res;
    endfunction

    function automatic seg_pair_t pack_pair(int c0, int c1, int c2, int c3,
                                            int c4, int c5, int c6, int c7);
        return {CW'(c0), CW'(c1), CW'(c2), CW'(c3), CW'(c4), CW'(c5), CW'(c6), CW'(c7)};
    endfunction

    function automatic int rnd(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // random pair, mostly shaped to reach crossings, touches and overlaps
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int sel, px, py, vx, vy, pick;
        do
        begin
            sel = $urandom_range(99);
            px = rnd(2000);
            py = rnd(2000);
            vx = rnd(50);
            vy = rnd(50);
            if (sel < 20)
                p = {$urandom, $urandom, $urandom, $urandom};
            else if (sel < 45)
                p = pack_pair(rnd(256), rnd(256), rnd(256), rnd(256),
                              rnd(256), rnd(256), rnd(256), rnd(256));
            else if (sel < 65)
            begin
                // segments along one line, vertical in some
                if (sel < 55)
                    vx = 0;
                p = pack_pair(px + rnd(20) * vx, py + rnd(20) * vy,
                              px + rnd(20) * vx, py + rnd(20) * vy,
                              px + rnd(20) * vx + ($urandom_range(3) == 0),
                              py + rnd(20) * vy,
                              px + rnd(20) * vx, py + rnd(20) * vy);
            end
            else if (sel < 85)
            begin
                // one vertex shared between the segments
                p = pack_pair(rnd(300), rnd(300), rnd(300), rnd(300),
                              rnd(300), rnd(300), rnd(300), rnd(300));
                pick = $urandom_range(3);
                if (pick[0])
                    {p.bx0, p.by0} = pick[1] ? {p.ax0, p.ay0} : {p.ax1, p.ay1};
                else
                    {p.bx1, p.by1} = pick[1] ? {p.ax0, p.ay0} : {p.ax1, p.ay1};
            end
            else
            begin
                // nearly parallel
                p = pack_pair(px, py, px + vx * 8, py + vy * 8,
                              px + rnd(30), py + rnd(30),
                              px + vx * 8 + rnd(1), py + vy * 8 + rnd(1));
            end
        end
        while (tol_cross == 0 && direction_cross(p) == 0);
        return p;
    endfunction

    task automatic report_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // driver: offers the oldest pending pair, holds it while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_meets.push_back(predict_meet(drv_pair));
                void'(pending_pairs.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    drv_pair <= pending_pairs[0];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transfer against the oldest expectation
    always @(posedge clk)
    begin : monitor
        result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_meets.size() == 0)
                begin
                    $display("%0t: result with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_meets.pop_front();
                    report_field("meet_kind", exp_r.kind, meet_kind);
                    report_field("at_a_begin", exp_r.at_a_begin, at_a_begin);
                    report_field("at_a_end", exp_r.at_a_end, at_a_end);
                    report_field("at_b_begin", exp_r.at_b_begin, at_b_begin);
                    report_field("at_b_end", exp_r.at_b_end, at_b_end);
                    report_field("point_valid", exp_r.point_valid, point_valid);
                    report_field("point_x", exp_r.point_x, point_x);
                    report_field("point_y", exp_r.point_y, point_y);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, longint value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CTW'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CROSS_TOL:   tol_cross  = value & 20'hFFFFF;
            CFG_RATIO_TOL:   tol_ratio  = value & 16'hFFFF;
            CFG_EDGE_MARGIN: tol_margin = value & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_pairs.size() > 0 || expected_meets.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin : stimulus
        longint cross_set[8]  = '{1, 0, 1048575, 1, 500, 40000, 3, 0};
        longint ratio_set[8]  = '{16, 0, 65535, 16, 2000, 300, 65535, 1};
        longint margin_set[8] = '{16, 0, 65535, 0, 3000, 65535, 5, 16};
        int idle_set[4]  = '{0, 80, 0, 38};
        int stall_set[4] = '{0, 0, 80, 38};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pairs under reset tolerances
        pending_pairs.push_back(pack_pair(32767, 32767, 32767, 32767,
                                          32767, 32767, 32767, 32767));
        pending_pairs.push_back(pack_pair(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, -32768));
        pending_pairs.push_back(pack_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pending_pairs.push_back(pack_pair(32767, 32767, 32766, 32767,
                                          0, -32768, 1, -32767));
        pending_pairs.push_back(pack_pair(-32768, 0, 32767, 1, 0, 32767, 1, -32768));
        pending_pairs.push_back(pack_pair(0, 0, 160, 0, 80, -80, 80, 80));
        pending_pairs.push_back(pack_pair(0, 0, 160, 0, 80, 0, 80, 80));
        pending_pairs.push_back(pack_pair(0, 0, 160, 0, 160, 0, 160, 80));
        pending_pairs.push_back(pack_pair(0, 0, 160, 0, 0, 0, 0, -80));
        pending_pairs.push_back(pack_pair(0, 0, 160, 0, 80, 80, 160, 0));
        pending_pairs.push_back(pack_pair(0, 0, 160, 0, 80, 0, 320, 0));
        pending_pairs.push_back(pack_pair(0, 0, 160, 0, 200, 0, 320, 0));
        pending_pairs.push_back(pack_pair(0, 0, 0, 160, 0, 80, 0, 320));
        pending_pairs.push_back(pack_pair(0, 0, 0, 160, 0, 200, 0, 320));
        pending_pairs.push_back(pack_pair(0, 0, 160, 0, 0, 16, 160, 16));
        pending_pairs.push_back(pack_pair(0, 0, 16, 16, 100, 0, 200, -16));
        pending_pairs.push_back(pack_pair(5, 5, 5, 5, 5, 5, 5, 5));
        pending_pairs.push_back(pack_pair(0, 0, 3, 7, 0, 3, 5, -1));
        pending_pairs.push_back(pack_pair(-3, 0, 3, 0, 0, -5, 1, 5));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_CROSS_TOL, cross_set[ph]);
            write_reg(CFG_RATIO_TOL, ratio_set[ph]);
            write_reg(CFG_EDGE_MARGIN, margin_set[ph]);
            send_idle_pct = idle_set[ph % 4];
            stall_pct = stall_set[ph % 4];
            for (int n = 0; n < 200; n++)
            begin
                // midway through phase 2 the sender holds off until every result is back
                if (ph == 2 && n == 100)
                    drain();
                pending_pairs.push_back(random_pair());
            end
            drain();
        end

        if (fail_count == 0 && expected_meets.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hdl/sic_pkg.sv
hdl/sic_front.sv
hdl/sic_div_cell.sv
hdl/sic_finish.sv
hdl/segment_intersection_classifier_top.sv
hdl/sic_checker.sv
bench/tb.sv
